// ===== rtl/core/ckb_pkg.sv =====
// ckb_pkg: payload types, register indexes and draw mode codes for the sprite blitter
// no dependencies

package ckb_pkg;

  localparam int PIXEL_W    = 32;
  localparam int KEY_W      = 24;
  localparam int ORIGIN_W   = 12;
  localparam int SIDE_W     = 11;
  localparam int PERCENT_W  = 7;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 10;
  localparam int SCREEN_X_W = 10;
  localparam int SCREEN_Y_W = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [PERCENT_W-1:0] PERCENT_FULL = 7'd100;
  localparam logic [PIXEL_W-1:0]   TINT_BITS    = 32'h00FF_0000;

  localparam logic [MODE_W-1:0] MODE_KEYED_COPY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OPAQUE_COPY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEYED_TINT  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_KEY     = 3'd0,
    REG_ORIGIN_X      = 3'd1,
    REG_ORIGIN_Y      = 3'd2,
    REG_SPRITE_WIDTH  = 3'd3,
    REG_SPRITE_HEIGHT = 3'd4,
    REG_DRAW_PERCENT  = 3'd5,
    REG_DRAW_MODE     = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] sprite_pixel;
  } pixel_t;

  typedef struct packed {
    logic [SCREEN_X_W-1:0] screen_x;
    logic [SCREEN_Y_W-1:0] screen_y;
    logic [PIXEL_W-1:0]    write_data;
    logic                  write_enable;
    logic                  last_pixel;
  } result_t;

endpackage

// ===== rtl/core/ckb_stream_if.sv =====
// ckb_stream_if: valid/ready stream channel carrying one payload per transfer
// payload type is a parameter, normally a struct from ckb_pkg

interface ckb_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ckb_cfg_if.sv =====
// ckb_cfg_if: register write channel, index and data under valid/ready
// depends on ckb_pkg for widths

interface ckb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ckb_pkg::CFG_IDX_W-1:0]   index;
  logic [ckb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/color_keyed_sprite_blitter.sv =====
// color_keyed_sprite_blitter: color keyed sprite blit with screen clipping
// depends on ckb_pkg, ckb_stream_if, ckb_cfg_if
//
// channel   dir  payload                                               transfer
// cfg       in   index, data                                           valid & ready
// pixels    in   sprite_pixel                                          valid & ready
// writes    out  screen_x, screen_y, write_data, write_enable, last    valid & ready
//
// one pixel per cycle while the skid register is empty; results are registered
// the pixel path is counters and compare logic into the output or skid register
// a skid register behind the output takes one more result when the output stalls
// rst is synchronous; it restores register defaults and clears the counters
// cfg is always ready

module color_keyed_sprite_blitter #(
  parameter int SCREEN_WIDTH    = 640,
  parameter int SCREEN_HEIGHT   = 480,
  parameter int MAX_SPRITE_SIDE = 1024
) (
  input  logic           clk,
  input  logic           rst,
  ckb_cfg_if.sink        cfg,
  ckb_stream_if.sink     pixels,
  ckb_stream_if.source   writes
);

  localparam int CW = ckb_pkg::COUNT_W;
  localparam int SW = ckb_pkg::SIDE_W;
  localparam int PW = ckb_pkg::PERCENT_W;
  localparam int OW = ckb_pkg::ORIGIN_W;

  logic [ckb_pkg::KEY_W-1:0] color_key;
  logic [OW-1:0]             origin_x;
  logic [OW-1:0]             origin_y;
  logic [SW-1:0]             sprite_width;
  logic [SW-1:0]             sprite_height;
  logic [PW-1:0]             draw_percent;
  logic [ckb_pkg::MODE_W-1:0] draw_mode;

  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [CW-1:0] column_count_next;
  logic [CW-1:0] row_count_next;

  ckb_pkg::result_t out_data;
  ckb_pkg::result_t skid_data;
  ckb_pkg::result_t result;
  logic             out_valid;
  logic             skid_valid;

  logic [SW-1:0]       width_eff;
  logic [SW-1:0]       height_eff;
  logic [PW-1:0]       percent_eff;
  logic [SW+PW-1:0]    shown_scaled;
  logic [SW+PW-1:0]    column_scaled;
  logic signed [OW:0]  sx;
  logic signed [OW:0]  sy;
  logic                row_end;
  logic                last;
  logic                visible;
  logic                keyed;
  logic                we;
  logic [ckb_pkg::PIXEL_W-1:0] pix;
  logic [ckb_pkg::PIXEL_W-1:0] data;
  logic                accept;
  logic                pop;

  // config writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_key     <= '0;
      origin_x      <= '0;
      origin_y      <= '0;
      sprite_width  <= SW'(1);
      sprite_height <= SW'(1);
      draw_percent  <= ckb_pkg::PERCENT_FULL;
      draw_mode     <= ckb_pkg::MODE_KEYED_COPY;
    end else if (cfg.valid) begin
      unique case (ckb_pkg::cfg_index_t'(cfg.index))
        ckb_pkg::REG_COLOR_KEY:     color_key     <= cfg.data[ckb_pkg::KEY_W-1:0];
        ckb_pkg::REG_ORIGIN_X:      origin_x      <= cfg.data[OW-1:0];
        ckb_pkg::REG_ORIGIN_Y:      origin_y      <= cfg.data[OW-1:0];
        ckb_pkg::REG_SPRITE_WIDTH:  sprite_width  <= cfg.data[SW-1:0];
        ckb_pkg::REG_SPRITE_HEIGHT: sprite_height <= cfg.data[SW-1:0];
        ckb_pkg::REG_DRAW_PERCENT:  draw_percent  <= cfg.data[PW-1:0];
        ckb_pkg::REG_DRAW_MODE:     draw_mode     <= cfg.data[ckb_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel path
  always_comb begin
    pix = pixels.data.sprite_pixel;

    if (sprite_width == '0) begin
      width_eff = SW'(1);
    end else if ({2'b00, sprite_width} > 13'(MAX_SPRITE_SIDE)) begin
      width_eff = SW'(MAX_SPRITE_SIDE);
    end else begin
      width_eff = sprite_width;
    end

    if (sprite_height == '0) begin
      height_eff = SW'(1);
    end else if ({2'b00, sprite_height} > 13'(MAX_SPRITE_SIDE)) begin
      height_eff = SW'(MAX_SPRITE_SIDE);
    end else begin
      height_eff = sprite_height;
    end

    percent_eff = (draw_percent > ckb_pkg::PERCENT_FULL) ? ckb_pkg::PERCENT_FULL
                                                         : draw_percent;

    // column < floor(w * pct / 100)  <=>  (column + 1) * 100 <= w * pct
    shown_scaled  = (SW+PW)'(width_eff) * (SW+PW)'(percent_eff);
    column_scaled = ((SW+PW)'(column_count) + (SW+PW)'(1)) * (SW+PW)'(ckb_pkg::PERCENT_FULL);

    sx = $signed({origin_x[OW-1], origin_x}) + $signed({3'b000, column_count});
    sy = $signed({origin_y[OW-1], origin_y}) + $signed({3'b000, row_count});

    row_end = ({1'b0, column_count} + SW'(1)) >= width_eff;
    last    = row_end && (({1'b0, row_count} + SW'(1)) >= height_eff);

    visible = (column_scaled <= shown_scaled)
           && !sx[OW] && ({1'b0, sx[OW-1:0]} < 13'(SCREEN_WIDTH))
           && !sy[OW] && ({1'b0, sy[OW-1:0]} < 13'(SCREEN_HEIGHT));
    keyed = (draw_mode != ckb_pkg::MODE_OPAQUE_COPY)
         && (pix[ckb_pkg::KEY_W-1:0] == color_key);
    we    = visible && !keyed;
    data  = (draw_mode == ckb_pkg::MODE_KEYED_TINT) ? (pix | ckb_pkg::TINT_BITS) : pix;

    result.screen_x     = we ? sx[ckb_pkg::SCREEN_X_W-1:0] : '0;
    result.screen_y     = we ? sy[ckb_pkg::SCREEN_Y_W-1:0] : '0;
    result.write_data   = we ? data : '0;
    result.write_enable = we;
    result.last_pixel   = last;

    if (last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (row_end) begin
      column_count_next = '0;
      row_count_next    = row_count + CW'(1);
    end else begin
      column_count_next = column_count + CW'(1);
      row_count_next    = row_count;
    end
  end

  // handshake: output register plus skid register
  assign pixels.ready = !skid_valid;
  assign accept       = pixels.valid && !skid_valid;
  assign pop          = out_valid && writes.ready;
  assign writes.valid = out_valid;
  assign writes.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      out_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        if (out_valid && !pop) begin
          skid_data  <= result;
          skid_valid <= 1'b1;
        end else begin
          out_data   <= result;
          out_valid  <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid  <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for color_keyed_sprite_blitter, predicts every write transfer
// depends on ckb_pkg, ckb_stream_if, ckb_cfg_if and the blitter rtl

module tb;
  import ckb_pkg::*;

  localparam int SCREEN_W      = 640;
  localparam int SCREEN_H      = 480;
  localparam int MAX_SIDE      = 1024;
  localparam int RANDOM_ITEMS  = 1120;
  localparam int QUIET_TAIL    = 150;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HANG_LIMIT    = 2000;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  logic clk;
  logic rst;

  ckb_cfg_if                        cfg_bus ();
  ckb_stream_if #(.data_t(pixel_t))  pix_bus ();
  ckb_stream_if #(.data_t(result_t)) wr_bus ();

  color_keyed_sprite_blitter #(
    .SCREEN_WIDTH   (SCREEN_W),
    .SCREEN_HEIGHT  (SCREEN_H),
    .MAX_SPRITE_SIDE(MAX_SIDE)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .pixels(pix_bus),
    .writes(wr_bus)
  );

  // shadow registers and counters, reset values
  logic [KEY_W-1:0]           key_reg  = '0;
  logic signed [ORIGIN_W-1:0] org_x    = '0;
  logic signed [ORIGIN_W-1:0] org_y    = '0;
  logic [SIDE_W-1:0]          wid_reg  = 11'd1;
  logic [SIDE_W-1:0]          hgt_reg  = 11'd1;
  logic [PERCENT_W-1:0]       pct_reg  = PERCENT_FULL;
  logic [MODE_W-1:0]          mode_reg = MODE_KEYED_COPY;
  logic [COUNT_W-1:0]         col_cnt  = '0;
  logic [COUNT_W-1:0]         row_cnt  = '0;

  result_t     sprite_results[$];
  bit          sprite_done;
  bit          gaps_on = 1'b1;
  int unsigned pixels_sent;
  int unsigned mismatches;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t blit_pixel(input logic [PIXEL_W-1:0] pix);
    int w, h, pct, shown, col, row, sx, sy;
    bit row_end, visible, keyed;
    result_t r;
    w = (wid_reg == 0) ? 1 : (wid_reg > MAX_SIDE) ? MAX_SIDE : int'(wid_reg);
    h = (hgt_reg == 0) ? 1 : (hgt_reg > MAX_SIDE) ? MAX_SIDE : int'(hgt_reg);
    pct = (pct_reg > PERCENT_FULL) ? int'(PERCENT_FULL) : int'(pct_reg);
    shown = w * pct / int'(PERCENT_FULL);
    col = int'(col_cnt);
    row = int'(row_cnt);
    sx = int'(org_x) + col;
    sy = int'(org_y) + row;
    row_end = (col + 1 >= w);
    sprite_done = row_end && (row + 1 >= h);
    visible = (col < shown) && (sx >= 0) && (sx < SCREEN_W) && (sy >= 0) && (sy < SCREEN_H);
    keyed = (mode_reg != MODE_OPAQUE_COPY) && (pix[KEY_W-1:0] == key_reg);
    r = '0;
    if (visible && !keyed) begin
      r.screen_x     = SCREEN_X_W'(sx);
      r.screen_y     = SCREEN_Y_W'(sy);
      r.write_data   = (mode_reg == MODE_KEYED_TINT) ? (pix | TINT_BITS) : pix;
      r.write_enable = 1'b1;
    end
    r.last_pixel = sprite_done;
    if (sprite_done) begin
      col_cnt = '0;
      row_cnt = '0;
    end else if (row_end) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [ORIGIN_W-1:0] pick_origin(input int side, input int screen);
    if ($urandom_range(0, 9) == 0)
      return ORIGIN_W'($urandom);
    return ORIGIN_W'($urandom_range(0, screen + side) - side);
  endfunction

  // register writes only once every pending write transfer has come back
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    pix_bus.valid <= 1'b0;
    do @(negedge clk); while (sprite_results.size() != 0);
    repeat (2) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_COLOR_KEY:     key_reg  = value[KEY_W-1:0];
      REG_ORIGIN_X:      org_x    = value[ORIGIN_W-1:0];
      REG_ORIGIN_Y:      org_y    = value[ORIGIN_W-1:0];
      REG_SPRITE_WIDTH:  wid_reg  = value[SIDE_W-1:0];
      REG_SPRITE_HEIGHT: hgt_reg  = value[SIDE_W-1:0];
      REG_DRAW_PERCENT:  pct_reg  = value[PERCENT_W-1:0];
      REG_DRAW_MODE:     mode_reg = value[MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      pix_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.data  <= pix;
    do @(posedge clk); while (!pix_bus.ready);
    sprite_results.push_back(blit_pixel(pix));
    pixels_sent++;
    @(negedge clk);
  endtask

  // cut of zero runs to the end of the sprite
  task automatic send_sprite(input int unsigned cut);
    int unsigned n;
    logic [PIXEL_W-1:0] pix;
    n = 0;
    do begin
      pix = $urandom;
      if ($urandom_range(0, 3) == 0)
        pix[KEY_W-1:0] = key_reg;
      send_pixel(pix);
      n++;
    end while (!sprite_done && (cut == 0 || n < cut));
  endtask

  task automatic test_reset_defaults();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFF00_0000);
    send_pixel(32'hFFFF_FFFF);
  endtask

  task automatic test_draw_modes();
    logic [MODE_W-1:0] modes[4];
    modes = '{MODE_KEYED_COPY, MODE_OPAQUE_COPY, MODE_KEYED_TINT, MODE_RESERVED};
    write_reg(REG_COLOR_KEY, 24'hFF_FFFF);
    write_reg(REG_SPRITE_WIDTH, 24'd2);
    write_reg(REG_ORIGIN_X, 24'd5);
    write_reg(REG_ORIGIN_Y, 24'd7);
    foreach (modes[i]) begin
      write_reg(REG_DRAW_MODE, 24'(modes[i]));
      send_pixel(32'h80FF_FFFF);
      send_pixel(32'h0000_1234);
    end
  endtask

  task automatic test_clipping();
    write_reg(REG_DRAW_MODE, 24'(MODE_OPAQUE_COPY));
    write_reg(REG_SPRITE_HEIGHT, 24'd2);
    write_reg(REG_ORIGIN_X, 24'h000FFF);
    write_reg(REG_ORIGIN_Y, 24'h000FFF);
    repeat (4) send_pixel($urandom);
    write_reg(REG_ORIGIN_X, 24'd639);
    write_reg(REG_ORIGIN_Y, 24'd479);
    repeat (4) send_pixel($urandom);
    write_reg(REG_SPRITE_WIDTH, 24'd1);
    write_reg(REG_SPRITE_HEIGHT, 24'd1);
    write_reg(REG_ORIGIN_X, 24'h000800);
    write_reg(REG_ORIGIN_Y, 24'h0007FF);
    send_pixel($urandom);
    write_reg(REG_ORIGIN_X, 24'h0007FF);
    write_reg(REG_ORIGIN_Y, 24'h000800);
    send_pixel($urandom);
  endtask

  task automatic test_draw_percent();
    write_reg(REG_ORIGIN_X, 24'd0);
    write_reg(REG_ORIGIN_Y, 24'd0);
    write_reg(REG_SPRITE_WIDTH, 24'd2);
    write_reg(REG_DRAW_PERCENT, 24'd0);
    repeat (2) send_pixel($urandom);
    write_reg(REG_SPRITE_WIDTH, 24'd1);
    write_reg(REG_DRAW_PERCENT, 24'd127);
    send_pixel($urandom);
  endtask

  // oversized and zero sides, then a shrink that leaves the counters past the end
  task automatic test_size_limits();
    write_reg(REG_ORIGIN_X, 24'd600);
    write_reg(REG_ORIGIN_Y, 24'd470);
    write_reg(REG_SPRITE_WIDTH, 24'd1024);
    write_reg(REG_SPRITE_HEIGHT, 24'd0);
    repeat (2) send_pixel($urandom);
    write_reg(REG_SPRITE_WIDTH, 24'd0);
    send_pixel($urandom);
    write_reg(REG_SPRITE_WIDTH, 24'd1);
    write_reg(REG_SPRITE_HEIGHT, 24'd2047);
    repeat (2) send_pixel($urandom);
    write_reg(REG_SPRITE_HEIGHT, 24'd0);
    send_pixel($urandom);
  endtask

  task automatic test_random_sprites();
    int unsigned target, w, h, cut;
    target = pixels_sent + RANDOM_ITEMS;
    while (pixels_sent < target) begin
      gaps_on = (target - pixels_sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) begin
        if ($urandom_range(0, 7) == 0)
          write_reg(REG_COLOR_KEY, $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h0);
        else
          write_reg(REG_COLOR_KEY, 24'($urandom));
      end
      if ($urandom_range(0, 1)) begin
        w = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 160) : $urandom_range(0, 24);
        h = $urandom_range(0, 8);
        write_reg(REG_SPRITE_WIDTH, 24'(w));
        write_reg(REG_SPRITE_HEIGHT, 24'(h));
      end
      if ($urandom_range(0, 1)) begin
        write_reg(REG_ORIGIN_X, 24'(pick_origin(int'(wid_reg), SCREEN_W)));
        write_reg(REG_ORIGIN_Y, 24'(pick_origin(int'(hgt_reg), SCREEN_H)));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_DRAW_PERCENT, $urandom_range(0, 1) ? 24'(PERCENT_FULL)
                                                         : 24'($urandom_range(0, 127)));
      if ($urandom_range(0, 1))
        write_reg(REG_DRAW_MODE, 24'($urandom_range(0, 3)));
      repeat ($urandom_range(1, 3)) begin
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : 0;
        send_sprite(cut);
      end
    end
  endtask

  // write side back-pressure in short bursts
  initial begin
    int unsigned hold;
    hold = 0;
    wr_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        wr_bus.ready <= 1'b0;
        hold--;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        wr_bus.ready <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        wr_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && wr_bus.valid && wr_bus.ready) begin
      got = wr_bus.data;
      if (sprite_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected write transfer: x=%0d y=%0d data=%h we=%b last=%b",
                   got.screen_x, got.screen_y, got.write_data, got.write_enable,
                   got.last_pixel);
      end else begin
        want = sprite_results.pop_front();
        if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
            got.write_data !== want.write_data || got.write_enable !== want.write_enable ||
            got.last_pixel !== want.last_pixel) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("write mismatch: exp x=%0d y=%0d data=%h we=%b last=%b, got x=%0d y=%0d data=%h we=%b last=%b",
                     want.screen_x, want.screen_y, want.write_data, want.write_enable,
                     want.last_pixel, got.screen_x, got.screen_y, got.write_data,
                     got.write_enable, got.last_pixel);
        end
      end
    end
  end

  // hang detection: cycles with no transfer on any channel
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((pix_bus.valid && pix_bus.ready) || (wr_bus.valid && wr_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_COLOR_KEY;
    cfg_bus.data  = '0;
    pix_bus.valid = 1'b0;
    pix_bus.data  = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_draw_modes();
    test_clipping();
    test_draw_percent();
    test_size_limits();
    test_random_sprites();
    pix_bus.valid <= 1'b0;
    while (sprite_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && sprite_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
